>>> hw/rtl/ddp_reassembly_tracker_macros.svh
// Assertion macros for the DDP reassembly tracker.
`ifndef DDP_REASSEMBLY_TRACKER_MACROS_SVH
`define DDP_REASSEMBLY_TRACKER_MACROS_SVH

`ifndef SYNTHESIS
`define DDPRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ddprt assertion failed");
`define DDPRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ddprt assertion failed");
`else
`define DDPRT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define DDPRT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hw/rtl/ddprt_pkg.sv
`default_nettype none
package ddprt_pkg;
	localparam int LEN_W = 32;
	localparam int PLEN_W = 16;
	localparam int OVH_W = 8;
	localparam int TAG_KEY_W = 32;
	localparam int QUEUE_KEY_W = 64;
	localparam int CFG_IDX_W = 1;
	localparam int STATUS_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_TAGGED_OVH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UNTAGGED_OVH = 1'd1;

	localparam logic [OVH_W-1:0] TAGGED_OVH_RST = 8'd14;
	localparam logic [OVH_W-1:0] UNTAGGED_OVH_RST = 8'd18;
	localparam logic [31:0] EXPECTED_SEQ_RST = 32'd1;

	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DROP = 2'd2;

	typedef struct packed {
		logic        is_tagged;
		logic        is_last;
		logic [31:0] steering_tag;
		logic [31:0] queue_number;
		logic [31:0] message_seq;
		logic [15:0] llp_length;
		logic [7:0]  ulp_control;
		logic [31:0] ulp_word;
		logic [7:0]  reserved_ulp;
	} ddprt_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        out_tagged;
		logic [31:0] out_tag;
		logic [31:0] out_queue;
		logic [31:0] out_seq;
		logic [31:0] total_length;
		logic [7:0]  out_ulp_control;
		logic [31:0] out_ulp_word;
		logic [7:0]  out_reserved_ulp;
	} ddprt_result_t;

	typedef struct packed {
		logic wr_en;
		logic set_vld;
		logic clr_vld;
	} ddprt_tbl_ctl_t;
endpackage
`default_nettype wire

>>> hw/rtl/ddprt_table.sv
`default_nettype none
module ddprt_table
	import ddprt_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int KEY_W = 32,
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [IDX_W-1:0]     rd_idx,
	output logic                      rd_valid_q,
	output logic [KEY_W-1:0]          rd_key_q,
	output logic [LEN_W-1:0]          rd_len_q,
	input  wire ddprt_tbl_ctl_t       ctl,
	input  wire logic [IDX_W-1:0]     wr_idx,
	input  wire logic [KEY_W-1:0]     wr_key,
	input  wire logic [LEN_W-1:0]     wr_len
);
	logic [DEPTH-1:0] valid_q;
	logic [KEY_W-1:0] key_mem [DEPTH];
	logic [LEN_W-1:0] len_mem [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[rd_idx];
			if (ctl.set_vld) begin
				valid_q[wr_idx] <= 1'b1;
			end else if (ctl.clr_vld) begin
				valid_q[wr_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			key_mem[wr_idx] <= wr_key;
			len_mem[wr_idx] <= wr_len;
		end
		rd_key_q <= key_mem[rd_idx];
		rd_len_q <= len_mem[rd_idx];
	end
endmodule
`default_nettype wire

>>> hw/rtl/ddp_reassembly_tracker.sv
// DDP segment reassembly tracker.
// An item is one received segment header on item, taken at a clock edge where
// start is high and busy is low. The block looks the segment up in the tagged
// or the untagged outstanding table, adds its payload length to the message,
// and on a last segment or a dropped segment reports one result on result,
// marked by done for exactly one cycle. Non-last segments that find or open an
// entry report nothing.
// The block holds busy while one compare unit walks the table of the segment's
// kind one entry a cycle through the registered read port of the table memory;
// a drain state then empties that port, and an update state writes the entry
// and the expected sequence counter. done rises on the edge that ends busy, and
// with start held high the next item is taken at the edge that ends the done
// cycle; no new item is taken while busy is high.
// The receiver cannot hold results off; a result is shown once and is gone.
// Reset clears all valid bits at once, sets the overhead registers to 14 and
// 18 and the expected sequence number to one. Configuration writes go through
// cfg_we, cfg_index and cfg_data and take effect on the next item.
`default_nettype none
`include "ddp_reassembly_tracker_macros.svh"
module ddp_reassembly_tracker
	import ddprt_pkg::*;
#(
	parameter int TAG_ENTRIES = 16,
	parameter int QUEUE_ENTRIES = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire ddprt_item_t          item,
	output logic                      done,
	output ddprt_result_t             result,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [OVH_W-1:0]     cfg_data
);
	localparam int TAG_IDX_W = (TAG_ENTRIES > 1) ? $clog2(TAG_ENTRIES) : 1;
	localparam int QUEUE_IDX_W = (QUEUE_ENTRIES > 1) ? $clog2(QUEUE_ENTRIES) : 1;
	localparam int SCAN_W = (TAG_IDX_W > QUEUE_IDX_W) ? TAG_IDX_W : QUEUE_IDX_W;
	localparam logic [SCAN_W-1:0] TAG_LAST = SCAN_W'(TAG_ENTRIES - 1);
	localparam logic [SCAN_W-1:0] QUEUE_LAST = SCAN_W'(QUEUE_ENTRIES - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_UPDATE
	} state_t;

	state_t state_q;
	ddprt_item_t item_q;
	logic [PLEN_W-1:0] len_q;
	logic [SCAN_W-1:0] scan_idx_q;
	logic chk_s1;
	logic [SCAN_W-1:0] chk_idx_s1;
	logic hit_q;
	logic [SCAN_W-1:0] hit_idx_q;
	logic [LEN_W-1:0] hit_len_q;
	logic free_q;
	logic [SCAN_W-1:0] free_idx_q;
	logic [31:0] expected_seq_q;
	logic done_q;
	ddprt_result_t result_q;
	logic [OVH_W-1:0] tag_ovh_q;
	logic [OVH_W-1:0] untag_ovh_q;

	logic [OVH_W-1:0] ovh;
	logic [PLEN_W-1:0] ovh_ext;
	logic [PLEN_W-1:0] payload_len;
	logic tag_rd_valid;
	logic [TAG_KEY_W-1:0] tag_rd_key;
	logic [LEN_W-1:0] tag_rd_len;
	logic q_rd_valid;
	logic [QUEUE_KEY_W-1:0] q_rd_key;
	logic [LEN_W-1:0] q_rd_len;
	logic sel_valid;
	logic [QUEUE_KEY_W-1:0] sel_key;
	logic [LEN_W-1:0] sel_len;
	logic [QUEUE_KEY_W-1:0] item_key;
	logic match;
	logic empty_slot;
	logic [SCAN_W-1:0] last_idx;
	logic [LEN_W-1:0] len_ext;
	logic [LEN_W-1:0] sum;
	ddprt_tbl_ctl_t upd_ctl;
	ddprt_tbl_ctl_t tag_ctl;
	ddprt_tbl_ctl_t q_ctl;
	logic [SCAN_W-1:0] wr_idx;
	logic emit;
	ddprt_result_t res_next;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_ovh_q <= TAGGED_OVH_RST;
			untag_ovh_q <= UNTAGGED_OVH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TAGGED_OVH: tag_ovh_q <= cfg_data;
				CFG_UNTAGGED_OVH: untag_ovh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		ovh = item.is_tagged ? tag_ovh_q : untag_ovh_q;
		ovh_ext = PLEN_W'(ovh);
		payload_len = (item.llp_length > ovh_ext) ? (item.llp_length - ovh_ext) : '0;
	end

	always_comb begin
		sel_valid = item_q.is_tagged ? tag_rd_valid : q_rd_valid;
		sel_key = item_q.is_tagged ? QUEUE_KEY_W'(tag_rd_key) : q_rd_key;
		sel_len = item_q.is_tagged ? tag_rd_len : q_rd_len;
		item_key = item_q.is_tagged ? QUEUE_KEY_W'(item_q.steering_tag)
			: {item_q.queue_number, item_q.message_seq};
		match = chk_s1 && sel_valid && (sel_key == item_key);
		empty_slot = chk_s1 && !sel_valid;
		last_idx = item_q.is_tagged ? TAG_LAST : QUEUE_LAST;
	end

	always_comb begin
		len_ext = LEN_W'(len_q);
		sum = hit_len_q + len_ext;
		upd_ctl = '0;
		wr_idx = hit_idx_q;
		if (state_q == S_UPDATE) begin
			if (hit_q) begin
				upd_ctl.wr_en = 1'b1;
				upd_ctl.clr_vld = item_q.is_last;
			end else if (!item_q.is_last && free_q) begin
				upd_ctl.wr_en = 1'b1;
				upd_ctl.set_vld = 1'b1;
				wr_idx = free_idx_q;
			end
		end
		tag_ctl = item_q.is_tagged ? upd_ctl : '0;
		q_ctl = item_q.is_tagged ? '0 : upd_ctl;

		emit = hit_q ? item_q.is_last : (item_q.is_last || !free_q);
		res_next = '0;
		res_next.out_tagged = item_q.is_tagged;
		res_next.total_length = hit_q ? sum : len_ext;
		if (item_q.is_tagged) begin
			res_next.out_tag = item_q.steering_tag;
			res_next.out_reserved_ulp = item_q.reserved_ulp;
		end else begin
			res_next.out_queue = item_q.queue_number;
			res_next.out_seq = item_q.message_seq;
			res_next.out_ulp_control = item_q.ulp_control;
			res_next.out_ulp_word = item_q.ulp_word;
		end
		priority if (!hit_q && !item_q.is_last && !free_q) begin
			res_next.status = ST_DROP;
		end else if (!item_q.is_tagged && item_q.is_last
				&& (expected_seq_q != item_q.message_seq)) begin
			res_next.status = ST_MISMATCH;
		end else begin
			res_next.status = ST_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			item_q <= '0;
			len_q <= '0;
			scan_idx_q <= '0;
			chk_s1 <= 1'b0;
			chk_idx_s1 <= '0;
			hit_q <= 1'b0;
			hit_idx_q <= '0;
			hit_len_q <= '0;
			free_q <= 1'b0;
			free_idx_q <= '0;
			expected_seq_q <= EXPECTED_SEQ_RST;
			done_q <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			chk_s1 <= (state_q == S_SCAN);
			chk_idx_s1 <= scan_idx_q;
			if (match && !hit_q) begin
				hit_q <= 1'b1;
				hit_idx_q <= chk_idx_s1;
				hit_len_q <= sel_len;
			end
			if (empty_slot && !free_q) begin
				free_q <= 1'b1;
				free_idx_q <= chk_idx_s1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						item_q <= item;
						len_q <= payload_len;
						scan_idx_q <= '0;
						hit_q <= 1'b0;
						free_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_idx_q == last_idx) begin
						state_q <= S_DRAIN;
					end else begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					done_q <= emit;
					result_q <= res_next;
					if (!item_q.is_tagged && item_q.is_last) begin
						expected_seq_q <= expected_seq_q + 1'b1;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	ddprt_table #(
		.DEPTH (TAG_ENTRIES),
		.KEY_W (TAG_KEY_W)
	) u_tag_tbl (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_idx     (scan_idx_q[TAG_IDX_W-1:0]),
		.rd_valid_q (tag_rd_valid),
		.rd_key_q   (tag_rd_key),
		.rd_len_q   (tag_rd_len),
		.ctl        (tag_ctl),
		.wr_idx     (wr_idx[TAG_IDX_W-1:0]),
		.wr_key     (item_q.steering_tag),
		.wr_len     (hit_q ? sum : len_ext)
	);

	ddprt_table #(
		.DEPTH (QUEUE_ENTRIES),
		.KEY_W (QUEUE_KEY_W)
	) u_queue_tbl (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_idx     (scan_idx_q[QUEUE_IDX_W-1:0]),
		.rd_valid_q (q_rd_valid),
		.rd_key_q   (q_rd_key),
		.rd_len_q   (q_rd_len),
		.ctl        (q_ctl),
		.wr_idx     (wr_idx[QUEUE_IDX_W-1:0]),
		.wr_key     ({item_q.queue_number, item_q.message_seq}),
		.wr_len     (hit_q ? sum : len_ext)
	);

	`DDPRT_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`DDPRT_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy)
	`DDPRT_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`DDPRT_ASSERT_NOW(a_no_drop_on_last, clk, arst_n, done && item_q.is_last, result.status != ST_DROP)
endmodule
`default_nettype wire

>>> tb/ddp_reassembly_tracker_checker.sv
module ddp_reassembly_tracker_checker
	import ddprt_pkg::*;
#(
	parameter int TAG_ENTRIES = 16,
	parameter int QUEUE_ENTRIES = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 busy,
	input  wire ddprt_item_t          item,
	input  wire logic                 done,
	input  wire ddprt_result_t        result,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [OVH_W-1:0]     cfg_data,
	output int                        failures,
	output int                        awaited,
	output int                        segments,
	output int                        completions,
	output int                        drops,
	output int                        seq_misses
);

	logic [OVH_W-1:0] tag_ovh;
	logic [OVH_W-1:0] untag_ovh;
	logic             tag_valid [TAG_ENTRIES];
	logic [31:0]      tag_key [TAG_ENTRIES];
	logic [31:0]      tag_len [TAG_ENTRIES];
	logic             queue_valid [QUEUE_ENTRIES];
	logic [31:0]      queue_qnum [QUEUE_ENTRIES];
	logic [31:0]      queue_seq [QUEUE_ENTRIES];
	logic [31:0]      queue_len [QUEUE_ENTRIES];
	logic [31:0]      want_seq;

	ddprt_result_t awaited_results [$];
	int fail_count;
	int segment_count;
	int completion_count;
	int drop_count;
	int miss_count;

	function automatic logic [31:0] payload_bytes(input logic [15:0] llp,
			input logic [OVH_W-1:0] ovh);
		return (llp > ovh) ? 32'(llp - ovh) : 32'd0;
	endfunction

	function automatic int field_differs(input string label, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
			return 1;
		end
		return 0;
	endfunction

	task automatic track_segment(input ddprt_item_t seg);
		ddprt_result_t res;
		logic [31:0] bytes;
		int hit;
		int spare;
		int i;
		hit = -1;
		spare = -1;
		res = '0;
		if (seg.is_tagged) begin
			bytes = payload_bytes(seg.llp_length, tag_ovh);
			for (i = 0; i < TAG_ENTRIES; i++) begin
				if (tag_valid[i]) begin
					if (hit < 0 && tag_key[i] == seg.steering_tag)
						hit = i;
				end else if (spare < 0) begin
					spare = i;
				end
			end
			if (hit >= 0) begin
				tag_len[hit] += bytes;
				if (!seg.is_last)
					return;
				bytes = tag_len[hit];
				tag_valid[hit] = 1'b0;
			end else if (!seg.is_last) begin
				if (spare < 0) begin
					res.status = ST_DROP;
				end else begin
					tag_valid[spare] = 1'b1;
					tag_key[spare] = seg.steering_tag;
					tag_len[spare] = bytes;
					return;
				end
			end
			res.out_tagged = 1'b1;
			res.out_tag = seg.steering_tag;
			res.out_reserved_ulp = seg.reserved_ulp;
		end else begin
			bytes = payload_bytes(seg.llp_length, untag_ovh);
			for (i = 0; i < QUEUE_ENTRIES; i++) begin
				if (queue_valid[i]) begin
					if (hit < 0 && queue_qnum[i] == seg.queue_number
							&& queue_seq[i] == seg.message_seq)
						hit = i;
				end else if (spare < 0) begin
					spare = i;
				end
			end
			if (hit >= 0) begin
				queue_len[hit] += bytes;
				if (!seg.is_last)
					return;
				bytes = queue_len[hit];
				queue_valid[hit] = 1'b0;
			end else if (!seg.is_last) begin
				if (spare < 0) begin
					res.status = ST_DROP;
				end else begin
					queue_valid[spare] = 1'b1;
					queue_qnum[spare] = seg.queue_number;
					queue_seq[spare] = seg.message_seq;
					queue_len[spare] = bytes;
					return;
				end
			end
			if (seg.is_last) begin
				res.status = (want_seq != seg.message_seq) ? ST_MISMATCH : ST_DONE;
				want_seq += 32'd1;
			end
			res.out_queue = seg.queue_number;
			res.out_seq = seg.message_seq;
			res.out_ulp_control = seg.ulp_control;
			res.out_ulp_word = seg.ulp_word;
		end
		res.total_length = bytes;
		if (res.status == ST_DROP)
			drop_count++;
		if (res.status == ST_MISMATCH)
			miss_count++;
		awaited_results.push_back(res);
	endtask

	task automatic compare_result(input ddprt_result_t got);
		ddprt_result_t want;
		int bad;
		if (awaited_results.size() == 0) begin
			$display("%0t: result with none expected, expected nothing, actual %h", $time, got);
			fail_count++;
			return;
		end
		want = awaited_results.pop_front();
		bad = field_differs("status", want.status, got.status)
			+ field_differs("out_tagged", want.out_tagged, got.out_tagged)
			+ field_differs("out_tag", want.out_tag, got.out_tag)
			+ field_differs("out_queue", want.out_queue, got.out_queue)
			+ field_differs("out_seq", want.out_seq, got.out_seq)
			+ field_differs("total_length", want.total_length, got.total_length)
			+ field_differs("out_ulp_control", want.out_ulp_control, got.out_ulp_control)
			+ field_differs("out_ulp_word", want.out_ulp_word, got.out_ulp_word)
			+ field_differs("out_reserved_ulp", want.out_reserved_ulp, got.out_reserved_ulp);
		fail_count += bad;
		completion_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_ovh = TAGGED_OVH_RST;
			untag_ovh = UNTAGGED_OVH_RST;
			want_seq = EXPECTED_SEQ_RST;
			foreach (tag_valid[i])
				tag_valid[i] = 1'b0;
			foreach (queue_valid[i])
				queue_valid[i] = 1'b0;
			awaited_results.delete();
			fail_count = 0;
			segment_count = 0;
			completion_count = 0;
			drop_count = 0;
			miss_count = 0;
		end else begin
			if (done)
				compare_result(result);
			if (cfg_we) begin
				if (cfg_index == CFG_TAGGED_OVH)
					tag_ovh = cfg_data;
				else if (cfg_index == CFG_UNTAGGED_OVH)
					untag_ovh = cfg_data;
			end
			if (start && !busy) begin
				segment_count++;
				track_segment(item);
			end
		end
		failures <= fail_count;
		awaited <= awaited_results.size();
		segments <= segment_count;
		completions <= completion_count;
		drops <= drop_count;
		seq_misses <= miss_count;
	end

endmodule

>>> tb/ddp_reassembly_tracker_test.sv
module ddp_reassembly_tracker_test;
	import ddprt_pkg::*;

	localparam int TAG_DEPTH = 16;
	localparam int QUEUE_DEPTH = 16;
	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASE_SEGMENTS = 560;

	typedef struct {
		logic        with_tag;
		logic [31:0] stag;
		logic [31:0] qn;
		logic [31:0] msn;
	} message_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	ddprt_item_t          item;
	logic                 done;
	ddprt_result_t        result;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [OVH_W-1:0]     cfg_data;

	int failures;
	int awaited;
	int segments;
	int completions;
	int drops;
	int seq_misses;
	int cycle_count = 0;
	int sender_idle_pct;
	logic [31:0] seq_hint;
	message_t open_messages [$];

	ddp_reassembly_tracker #(
		.TAG_ENTRIES(TAG_DEPTH),
		.QUEUE_ENTRIES(QUEUE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	ddp_reassembly_tracker_checker #(
		.TAG_ENTRIES(TAG_DEPTH),
		.QUEUE_ENTRIES(QUEUE_DEPTH)
	) tracker_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.failures(failures),
		.awaited(awaited),
		.segments(segments),
		.completions(completions),
		.drops(drops),
		.seq_misses(seq_misses)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [15:0] random_llp();
		int roll;
		roll = $urandom_range(99);
		if (roll < 5)
			return 16'hFFFF;
		if (roll < 12)
			return 16'($urandom);
		if (roll < 25)
			return 16'($urandom_range(300));
		return 16'($urandom_range(4000));
	endfunction

	function automatic ddprt_item_t build_segment(input logic with_tag, input logic last,
			input logic [31:0] stag, input logic [31:0] qn, input logic [31:0] msn,
			input logic [15:0] llp);
		ddprt_item_t seg;
		seg.is_tagged = with_tag;
		seg.is_last = last;
		seg.steering_tag = stag;
		seg.queue_number = qn;
		seg.message_seq = msn;
		seg.llp_length = llp;
		seg.ulp_control = 8'($urandom);
		seg.ulp_word = $urandom;
		seg.reserved_ulp = 8'($urandom);
		return seg;
	endfunction

	// Mostly well-formed messages: open, continue, close, with a few stray segments.
	function automatic ddprt_item_t next_segment();
		message_t msg;
		int roll;
		int pick;
		int untagged_open;
		logic last;
		roll = $urandom_range(99);
		if (roll < 8)
			return build_segment(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom,
				$urandom, $urandom, random_llp());
		if (open_messages.size() == 0 || (roll < 35 && open_messages.size() < 28)) begin
			untagged_open = 0;
			foreach (open_messages[i])
				if (!open_messages[i].with_tag)
					untagged_open++;
			msg.with_tag = 1'($urandom_range(1));
			msg.stag = ($urandom_range(3) == 0) ? $urandom : $urandom_range(63);
			msg.qn = ($urandom_range(3) == 0) ? $urandom : $urandom_range(7);
			msg.msn = ($urandom_range(9) == 0) ? $urandom : seq_hint + untagged_open;
			open_messages.push_back(msg);
			return build_segment(msg.with_tag, 1'b0, msg.stag, msg.qn, msg.msn, random_llp());
		end
		pick = $urandom_range(1) ? 0 : $urandom_range(open_messages.size() - 1);
		msg = open_messages[pick];
		last = ($urandom_range(99) < 40);
		if (last)
			open_messages.delete(pick);
		return build_segment(msg.with_tag, last, msg.stag, msg.qn, msg.msn, random_llp());
	endfunction

	task automatic send_segment(input ddprt_item_t seg);
		if ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
		item <= seg;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		if (!seg.is_tagged && seg.is_last)
			seq_hint += 32'd1;
	endtask

	task automatic settle();
		start <= 1'b0;
		do
			@(posedge clk);
		while (awaited != 0 || busy);
		repeat (24) @(posedge clk);
	endtask

	task automatic write_overheads(input logic [OVH_W-1:0] tag_ovh,
			input logic [OVH_W-1:0] untag_ovh);
		cfg_we <= 1'b1;
		cfg_index <= CFG_TAGGED_OVH;
		cfg_data <= tag_ovh;
		@(posedge clk);
		cfg_index <= CFG_UNTAGGED_OVH;
		cfg_data <= untag_ovh;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		ddprt_item_t seg;
		int phase;
		int n;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_TAGGED_OVH;
		cfg_data = '0;
		arst_n = 1'b0;
		sender_idle_pct = 0;
		seq_hint = EXPECTED_SEQ_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_segment(build_segment(1'b1, 1'b1, 32'd0, 32'd0, 32'd0, 16'd0));
		seg = build_segment(1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		seg.reserved_ulp = 8'hFF;
		send_segment(seg);
		seg = build_segment(1'b0, 1'b1, 32'd0, 32'hFFFF_FFFF, 32'd1, 16'd18);
		seg.ulp_control = 8'hFF;
		seg.ulp_word = 32'hFFFF_FFFF;
		send_segment(seg);
		seg = build_segment(1'b0, 1'b1, 32'hFFFF_FFFF, 32'd0, 32'd0, 16'hFFFF);
		seg.ulp_control = '0;
		seg.ulp_word = '0;
		seg.reserved_ulp = '0;
		send_segment(seg);
		send_segment(build_segment(1'b0, 1'b0, 32'd0, 32'd0, 32'd3, 16'd5));
		send_segment(build_segment(1'b0, 1'b0, 32'd0, 32'd0, 32'd3, 16'd500));
		send_segment(build_segment(1'b0, 1'b1, 32'd0, 32'd0, 32'd3, 16'd100));
		send_segment(build_segment(1'b0, 1'b0, 32'd0, 32'd1, 32'd9, 16'd40));
		open_messages.push_back('{1'b0, 32'd0, 32'd1, 32'd9});
		for (n = 0; n < TAG_DEPTH; n++) begin
			send_segment(build_segment(1'b1, 1'b0, n, 32'd0, 32'd0, random_llp()));
			open_messages.push_back('{1'b1, n, 32'd0, 32'd0});
		end
		send_segment(build_segment(1'b1, 1'b0, 32'h0000_DEAD, 32'd0, 32'd0, 16'd300));
		open_messages.push_back('{1'b1, 32'h0000_DEAD, 32'd0, 32'd0});

		for (phase = 0; phase < 3; phase++) begin
			settle();
			case (phase)
				0: begin
					sender_idle_pct = 35;
					write_overheads(8'd0, 8'd255);
				end
				1: begin
					sender_idle_pct = 47;
					write_overheads(8'd255, 8'd0);
				end
				default: begin
					sender_idle_pct = 0;
					write_overheads(8'($urandom_range(255)), 8'($urandom_range(255)));
				end
			endcase
			repeat (PHASE_SEGMENTS) send_segment(next_segment());
		end
		settle();

		$display("Covered %0d segments under the reset, zero, full-scale and random overheads,",
			segments);
		$display("with %0d results seen, %0d of them drops and %0d sequence mismatches.",
			completions, drops, seq_misses);
		if (failures == 0 && awaited == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> ddp_reassembly_tracker.f
+incdir+hw/rtl
hw/rtl/ddprt_pkg.sv
hw/rtl/ddprt_table.sv
hw/rtl/ddp_reassembly_tracker.sv
tb/ddp_reassembly_tracker_checker.sv
tb/ddp_reassembly_tracker_test.sv
